### hw/rtl/rept_pkg.sv
// Package for the rotary encoder position tracker.
// Holds command and mode codes, register indexes, reset values and the
// controller-to-datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package rept_pkg;

   // Request command codes.
   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_TOGGLE = 2'd2;

   // Range mode codes.
   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_CLAMP = 2'd1;
   localparam logic [1:0] MODE_WRAP  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_RANGE_MODE = 2'd0;
   localparam logic [1:0] CSR_BOUND_LOW  = 2'd1;
   localparam logic [1:0] CSR_BOUND_HIGH = 2'd2;
   localparam logic [1:0] CSR_STEP_SIZE  = 2'd3;

   // Register reset values.
   localparam logic [1:0]         RANGE_MODE_RST = MODE_PLAIN;
   localparam logic signed [31:0] BOUND_LOW_RST  = 32'sd0;
   localparam logic signed [31:0] BOUND_HIGH_RST = 32'sd100;
   localparam logic signed [15:0] STEP_SIZE_RST  = 16'sd1;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // The wrap remainder is found one quotient bit per cycle.
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   typedef struct packed {
      logic sample;    // apply a pin sample word
      logic toggle;    // flip listening, clear count
      logic read;      // capture start, form product, clear count
      logic sum;       // saturated start plus product
      logic order;     // put the bounds in order
      logic setup;     // prepare the remainder search
      logic div_step;  // one restoring remainder step
      logic finish;    // shape the value into the output register
   } rept_cmd_type;

   typedef struct packed {
      logic wrap_mode;
   } rept_status_type;

endpackage

### hw/rtl/rept_ctrl.sv
// Controller state machine of the rotary encoder position tracker.
// Sequences a read through the datapath and owns the handshake flags.
// Depends on rept_pkg.
`timescale 1ns / 1ps

module rept_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_command,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  rept_pkg::rept_status_type status,
   output rept_pkg::rept_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_ORDER,
      ST_SETUP,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type                      state_ff, state_in;
   logic [rept_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_command)
                  rept_pkg::CMD_SAMPLE: cmd.sample = 1'b1;
                  rept_pkg::CMD_TOGGLE: cmd.toggle = 1'b1;
                  rept_pkg::CMD_READ: begin
                     cmd.read = 1'b1;
                     state_in = ST_SUM;
                  end
                  default: ;
               endcase
            end
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_ORDER;
         end
         ST_ORDER: begin
            cmd.order = 1'b1;
            state_in  = status.wrap_mode ? ST_SETUP : ST_FIN;
         end
         ST_SETUP: begin
            cmd.setup  = 1'b1;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == rept_pkg::DIV_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Wait here until the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/rept_dp.sv
// Datapath of the rotary encoder position tracker: configuration
// registers, step counter, multiply, saturating add, bound shaping and
// a bit-serial remainder unit. Depends on rept_pkg.
`timescale 1ns / 1ps

module rept_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [31:0]               csr_write_data,
   input  logic                      req_clk_level,
   input  logic                      req_dt_level,
   input  logic signed [31:0]        req_start_position,
   output logic signed [31:0]        rsp_position,
   input  rept_pkg::rept_cmd_type    cmd,
   output rept_pkg::rept_status_type status
);

   logic [1:0]         range_mode_ff;
   logic signed [31:0] bound_low_ff;
   logic signed [31:0] bound_high_ff;
   logic signed [15:0] step_size_ff;

   logic signed [31:0] step_count_ff, step_count_in;
   logic               last_clk_ff, last_clk_in;
   logic               listening_ff, listening_in;

   logic signed [31:0] start_ff;
   logic signed [47:0] prod_ff;
   logic signed [31:0] val_ff;
   logic signed [31:0] lo_ff, hi_ff;
   logic [31:0]        mag_ff, rem_ff, period_ff;
   logic               neg_ff;
   logic signed [31:0] position_ff, position_in;

   logic signed [31:0] prod_sat;
   logic signed [32:0] sum_wide;
   logic signed [31:0] sum_sat;
   logic signed [32:0] diff_wide;
   logic [32:0]        div_trial;
   logic [31:0]        wrap_r;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         range_mode_ff <= rept_pkg::RANGE_MODE_RST;
         bound_low_ff  <= rept_pkg::BOUND_LOW_RST;
         bound_high_ff <= rept_pkg::BOUND_HIGH_RST;
         step_size_ff  <= rept_pkg::STEP_SIZE_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rept_pkg::CSR_RANGE_MODE: range_mode_ff <= csr_write_data[1:0];
            rept_pkg::CSR_BOUND_LOW:  bound_low_ff  <= csr_write_data;
            rept_pkg::CSR_BOUND_HIGH: bound_high_ff <= csr_write_data;
            rept_pkg::CSR_STEP_SIZE:  step_size_ff  <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // Encoder tracking state.
   always_comb begin
      step_count_in = step_count_ff;
      last_clk_in   = last_clk_ff;
      listening_in  = listening_ff;
      if (cmd.sample && listening_ff) begin
         if (!last_clk_ff && req_clk_level) begin
            if (req_dt_level) begin
               if (step_count_ff != rept_pkg::S32_MAX) begin
                  step_count_in = step_count_ff + 32'sd1;
               end
            end else if (step_count_ff != rept_pkg::S32_MIN) begin
               step_count_in = step_count_ff - 32'sd1;
            end
         end
         last_clk_in = req_clk_level;
      end else if (cmd.toggle) begin
         listening_in  = !listening_ff;
         last_clk_in   = 1'b0;
         step_count_in = '0;
      end else if (cmd.read) begin
         step_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= '0;
         last_clk_ff   <= 1'b0;
         listening_ff  <= 1'b0;
      end else begin
         step_count_ff <= step_count_in;
         last_clk_ff   <= last_clk_in;
         listening_ff  <= listening_in;
      end
   end

   // The product fits 32 bits only when its top 17 bits agree.
   always_comb begin
      if ((&prod_ff[47:31]) || !(|prod_ff[47:31])) begin
         prod_sat = prod_ff[31:0];
      end else begin
         prod_sat = prod_ff[47] ? rept_pkg::S32_MIN : rept_pkg::S32_MAX;
      end
      sum_wide = {start_ff[31], start_ff} + {prod_sat[31], prod_sat};
      if (sum_wide[32] != sum_wide[31]) begin
         sum_sat = sum_wide[32] ? rept_pkg::S32_MIN : rept_pkg::S32_MAX;
      end else begin
         sum_sat = sum_wide[31:0];
      end
      diff_wide = {val_ff[31], val_ff} - {lo_ff[31], lo_ff};
      div_trial = {rem_ff, mag_ff[31]};
   end

   // Read pipeline and remainder unit.
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         start_ff <= req_start_position;
         prod_ff  <= 48'(step_count_ff) * 48'(step_size_ff);
      end
      if (cmd.sum) begin
         val_ff <= sum_sat;
      end
      if (cmd.order) begin
         if (bound_low_ff > bound_high_ff) begin
            lo_ff <= bound_high_ff;
            hi_ff <= bound_low_ff;
         end else begin
            lo_ff <= bound_low_ff;
            hi_ff <= bound_high_ff;
         end
      end
      if (cmd.setup) begin
         // The period and the distance magnitude are below 2^32; the period is zero only for equal bounds.
         neg_ff    <= diff_wide[32];
         mag_ff    <= diff_wide[32] ? 32'(-diff_wide) : diff_wide[31:0];
         period_ff <= 32'(hi_ff - lo_ff);
         rem_ff    <= '0;
      end
      if (cmd.div_step) begin
         mag_ff <= {mag_ff[30:0], 1'b0};
         if (div_trial >= {1'b0, period_ff}) begin
            rem_ff <= 32'(div_trial - {1'b0, period_ff});
         end else begin
            rem_ff <= div_trial[31:0];
         end
      end
      position_ff <= position_in;
   end

   // Shaping. With distinct bounds a wrap result lies in (lo, hi], so a zero remainder maps to the period.
   always_comb begin
      if (rem_ff == '0) begin
         wrap_r = period_ff;
      end else if (neg_ff) begin
         wrap_r = period_ff - rem_ff;
      end else begin
         wrap_r = rem_ff;
      end
      position_in = position_ff;
      if (cmd.finish) begin
         case (range_mode_ff)
            rept_pkg::MODE_CLAMP: begin
               if (lo_ff == hi_ff) begin
                  position_in = lo_ff;
               end else if (val_ff >= hi_ff) begin
                  position_in = hi_ff - 32'sd1;
               end else if (val_ff <= lo_ff) begin
                  position_in = lo_ff + 32'sd1;
               end else begin
                  position_in = val_ff;
               end
            end
            rept_pkg::MODE_WRAP: begin
               if (lo_ff == hi_ff) begin
                  position_in = lo_ff;
               end else begin
                  position_in = lo_ff + $signed(wrap_r);
               end
            end
            default: position_in = val_ff;
         endcase
      end
   end

   assign rsp_position     = position_ff;
   assign status.wrap_mode = (range_mode_ff == rept_pkg::MODE_WRAP);

endmodule

### hw/rtl/rotary_encoder_position_tracker.sv
// Rotary encoder position tracker, top level. Pin sample and toggle words are
// accepted back to back. A read word stalls the input through the sum, order and
// finish states, in wrap mode also through setup and the 32-step bit-serial
// remainder unit, and finish waits while a result is still stalled at the output;
// its result waits in an output register while new words are accepted. Synchronous
// reset clears the count, listening and output valid and restores register defaults.
`timescale 1ns / 1ps

module rotary_encoder_position_tracker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic               req_clk_level,
   input  logic               req_dt_level,
   input  logic signed [31:0] req_start_position,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_position
);

   rept_pkg::rept_cmd_type    cmd;
   rept_pkg::rept_status_type status;

   rept_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   rept_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_clk_level      (req_clk_level),
      .req_dt_level       (req_dt_level),
      .req_start_position (req_start_position),
      .rsp_position       (rsp_position),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

### hw/rtl/rept_checker.sv
// Port-level checker for the rotary encoder position tracker, bound to the
// top level. Depends on rept_pkg.
`timescale 1ns / 1ps

module rept_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_command,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_position
);

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position))
      else $error("stalled result word changed");

   // An accepted read occupies the block in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == rept_pkg::CMD_READ |=> req_stall)
      else $error("read word did not occupy the block");

   // Other words finish in the cycle they are accepted.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command != rept_pkg::CMD_READ |=> !req_stall)
      else $error("non-read word stalled the input");

   // A result only appears at the end of a busy read.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word without a read in progress");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

endmodule

bind rotary_encoder_position_tracker rept_checker u_rept_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_command  (req_command),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_position (rsp_position)
);

### bench/rotary_encoder_position_tracker_tb.sv
// Self-checking testbench for the rotary encoder position tracker. Drives pin
// sample, read and toggle words plus register writes, and checks every position against
// a behavioral predictor or a fixed expectation. Depends on rept_pkg and the top level.
`timescale 1ns / 1ps

module rotary_encoder_position_tracker_tb;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SEGMENTS      = 5;
   localparam int SEGMENT_WORDS = 25;
   localparam longint POS_MAX   = 64'sd2147483647;
   localparam longint POS_MIN   = -64'sd2147483648;

   typedef enum logic {ROW_WORD, ROW_REG} row_kind_type;

   // For a register row, code is the register index and value its data.
   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   code;
      logic         clk_lvl;
      logic         dt_lvl;
      logic [31:0]  value;
      logic         typed;
      logic [31:0]  typed_pos;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 37;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_WORD, rept_pkg::CMD_READ, 1'b0, 1'b0, rept_pkg::S32_MAX, 1'b1, rept_pkg::S32_MAX},
      '{ROW_WORD, rept_pkg::CMD_READ, 1'b0, 1'b0, rept_pkg::S32_MIN, 1'b1, rept_pkg::S32_MIN},
      '{ROW_WORD, rept_pkg::CMD_SAMPLE, 1'b1, 1'b1, 32'd0, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_READ, 1'b0, 1'b0, 32'sd5, 1'b1, 32'sd5},
      '{ROW_WORD, CMD_UNUSED, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_TOGGLE, 1'b0, 1'b0, 32'd0, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_SAMPLE, 1'b1, 1'b1, 32'd0, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_SAMPLE, 1'b0, 1'b0, 32'd0, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_SAMPLE, 1'b1, 1'b1, 32'd0, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_SAMPLE, 1'b1, 1'b0, 32'd0, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_READ, 1'b0, 1'b0, rept_pkg::S32_MAX, 1'b0, 32'd0},
      '{ROW_REG, rept_pkg::CSR_STEP_SIZE, 1'b0, 1'b0, 32'hFFFF_8000, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_SAMPLE, 1'b0, 1'b0, 32'd0, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_SAMPLE, 1'b1, 1'b1, 32'd0, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_READ, 1'b0, 1'b0, rept_pkg::S32_MIN, 1'b0, 32'd0},
      '{ROW_REG, rept_pkg::CSR_STEP_SIZE, 1'b0, 1'b0, 32'h0000_7FFF, 1'b0, 32'd0},
      '{ROW_REG, rept_pkg::CSR_RANGE_MODE, 1'b0, 1'b0, 32'(rept_pkg::MODE_CLAMP), 1'b0, 32'd0},
      '{ROW_REG, rept_pkg::CSR_BOUND_LOW, 1'b0, 1'b0, 32'sd100, 1'b0, 32'd0},
      '{ROW_REG, rept_pkg::CSR_BOUND_HIGH, 1'b0, 1'b0, -32'sd50, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_READ, 1'b0, 1'b0, 32'd0, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_READ, 1'b0, 1'b0, 32'sd1000, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_SAMPLE, 1'b0, 1'b0, 32'd0, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_SAMPLE, 1'b1, 1'b0, 32'd0, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_READ, 1'b0, 1'b0, 32'd0, 1'b0, 32'd0},
      '{ROW_REG, rept_pkg::CSR_RANGE_MODE, 1'b0, 1'b0, 32'(rept_pkg::MODE_WRAP), 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_READ, 1'b0, 1'b0, 32'd0, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_READ, 1'b0, 1'b0, 32'sd250, 1'b0, 32'd0},
      '{ROW_REG, rept_pkg::CSR_BOUND_LOW, 1'b0, 1'b0, 32'sd7, 1'b0, 32'd0},
      '{ROW_REG, rept_pkg::CSR_BOUND_HIGH, 1'b0, 1'b0, 32'sd7, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_READ, 1'b0, 1'b0, 32'sd3, 1'b1, 32'sd7},
      '{ROW_REG, rept_pkg::CSR_RANGE_MODE, 1'b0, 1'b0, 32'(MODE_UNUSED), 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_READ, 1'b0, 1'b0, 32'sd42, 1'b1, 32'sd42},
      '{ROW_REG, rept_pkg::CSR_RANGE_MODE, 1'b0, 1'b0, 32'(rept_pkg::MODE_WRAP), 1'b0, 32'd0},
      '{ROW_REG, rept_pkg::CSR_BOUND_LOW, 1'b0, 1'b0, rept_pkg::S32_MIN, 1'b0, 32'd0},
      '{ROW_REG, rept_pkg::CSR_BOUND_HIGH, 1'b0, 1'b0, rept_pkg::S32_MAX, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_READ, 1'b0, 1'b0, rept_pkg::S32_MIN, 1'b0, 32'd0},
      '{ROW_WORD, rept_pkg::CMD_TOGGLE, 1'b0, 1'b0, 32'd0, 1'b0, 32'd0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_write_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_command = rept_pkg::CMD_SAMPLE;
   logic               req_clk_level = 1'b0;
   logic               req_dt_level = 1'b0;
   logic signed [31:0] req_start_position = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_position;

   // Fixed expectation that travels with a directed word.
   logic               req_typed = 1'b0;
   logic signed [31:0] req_typed_pos = '0;

   // Predictor state and its copy of the registers.
   logic [1:0]         cfg_mode;
   logic signed [31:0] cfg_low;
   logic signed [31:0] cfg_high;
   logic signed [15:0] cfg_step;
   logic signed [31:0] enc_count;
   logic               enc_last_clk;
   logic               enc_listening;

   logic signed [31:0] expected_positions [$];

   int send_idle_pct = 21;
   int rsp_stall_pct = 71;
   int mismatches = 0;
   int words_sent = 0;
   int positions_checked = 0;
   int reg_writes = 0;
   int quiet_cycles = 0;

   rotary_encoder_position_tracker u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_clk_level      (req_clk_level),
      .req_dt_level       (req_dt_level),
      .req_start_position (req_start_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_position       (rsp_position)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint sat_s32(input longint v);
      if (v > POS_MAX)
         return POS_MAX;
      if (v < POS_MIN)
         return POS_MIN;
      return v;
   endfunction

   function automatic longint shaped_position(input longint v);
      longint lo;
      longint hi;
      longint t;
      longint period;
      longint r;
      if (cfg_mode != rept_pkg::MODE_CLAMP && cfg_mode != rept_pkg::MODE_WRAP)
         return v;
      lo = cfg_low;
      hi = cfg_high;
      if (lo > hi) begin
         t = lo;
         lo = hi;
         hi = t;
      end
      if (lo == hi)
         return lo;
      if (cfg_mode == rept_pkg::MODE_CLAMP) begin
         // The upper limit wins when both could apply.
         if (v > hi - 1)
            v = hi - 1;
         else if (v < lo + 1)
            v = lo + 1;
         return sat_s32(v);
      end
      // Land in the half-open range above the low bound.
      period = hi - lo;
      r = (v - lo) % period;
      if (r < 0)
         r += period;
      if (r == 0)
         r = period;
      return lo + r;
   endfunction

   function automatic void track_word(input logic [1:0] cmd, input logic clk_lvl,
                                      input logic dt_lvl, input logic signed [31:0] start,
                                      input logic typed, input logic signed [31:0] typed_pos);
      longint sum;
      case (cmd)
         rept_pkg::CMD_SAMPLE: begin
            if (enc_listening) begin
               if (!enc_last_clk && clk_lvl)
                  enc_count = 32'(sat_s32(longint'(enc_count) + (dt_lvl ? 64'sd1 : -64'sd1)));
               enc_last_clk = clk_lvl;
            end
         end
         rept_pkg::CMD_READ: begin
            sum = sat_s32(longint'(start) + sat_s32(longint'(enc_count) * longint'(cfg_step)));
            enc_count = '0;
            expected_positions.push_back(typed ? typed_pos : 32'(shaped_position(sum)));
         end
         rept_pkg::CMD_TOGGLE: begin
            enc_listening = !enc_listening;
            enc_last_clk = 1'b0;
            enc_count = '0;
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string line);
      mismatches++;
      $display("mismatch: %s", line);
   endtask

   function automatic logic [31:0] pick_bound();
      case ($urandom_range(0, 5))
         0: return rept_pkg::S32_MIN;
         1: return rept_pkg::S32_MAX;
         2: return 32'd0;
         3: return $urandom();
         default: return 32'($urandom_range(0, 400)) - 32'd200;
      endcase
   endfunction

   // Predictor, checker and watchdog, all on the sampling edge.
   always @(posedge clock) begin : monitor
      logic signed [31:0] want;
      bit progress;
      progress = 1'b0;
      if (reset) begin
         cfg_mode = rept_pkg::RANGE_MODE_RST;
         cfg_low = rept_pkg::BOUND_LOW_RST;
         cfg_high = rept_pkg::BOUND_HIGH_RST;
         cfg_step = rept_pkg::STEP_SIZE_RST;
         enc_count = '0;
         enc_last_clk = 1'b0;
         enc_listening = 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               rept_pkg::CSR_RANGE_MODE: cfg_mode = csr_write_data[1:0];
               rept_pkg::CSR_BOUND_LOW:  cfg_low = csr_write_data;
               rept_pkg::CSR_BOUND_HIGH: cfg_high = csr_write_data;
               rept_pkg::CSR_STEP_SIZE:  cfg_step = csr_write_data[15:0];
               default: ;
            endcase
            progress = 1'b1;
         end
         if (req_valid && !req_stall) begin
            track_word(req_command, req_clk_level, req_dt_level, req_start_position,
                       req_typed, req_typed_pos);
            progress = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            progress = 1'b1;
            positions_checked++;
            if (expected_positions.size() == 0) begin
               report_mismatch($sformatf("position %0d arrived with none expected",
                                         rsp_position));
            end else begin
               want = expected_positions.pop_front();
               if (rsp_position !== want)
                  report_mismatch($sformatf("position %0d, expected %0d",
                                            rsp_position, want));
            end
         end
         quiet_cycles = progress ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("FAIL rotary_encoder_position_tracker");
            $finish;
         end
      end
   end

   always @(negedge clock)
      rsp_stall <= !reset && ($urandom_range(0, 99) < rsp_stall_pct);

   // Called and returning just after a falling edge.
   task automatic send_word(input logic [1:0] cmd, input logic clk_lvl, input logic dt_lvl,
                            input logic [31:0] start, input logic typed,
                            input logic [31:0] typed_pos);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_clk_level <= clk_lvl;
      req_dt_level <= dt_lvl;
      req_start_position <= start;
      req_typed <= typed;
      req_typed_pos <= typed_pos;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      reg_writes++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (expected_positions.size() != 0);
   endtask

   // Pin sample and toggle words leave no result, so give them time to retire.
   task automatic quiesce();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int send_pcts [3];
      int stall_pcts [3];
      int seg_words;
      int n;
      stim_row_type row;
      bit after_word;
      logic [31:0] rnd;
      logic [31:0] lo_w;
      logic [31:0] hi_w;
      logic [1:0] mode_w;
      logic [15:0] step_w;
      logic dir;

      send_pcts = '{21, 71, 0};
      stall_pcts = '{71, 21, 0};
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      after_word = 1'b0;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_REG) begin
            if (after_word)
               quiesce();
            write_reg(row.code, row.value);
            after_word = 1'b0;
         end else begin
            send_word(row.code, row.clk_lvl, row.dt_lvl, row.value, row.typed, row.typed_pos);
            after_word = 1'b1;
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = send_pcts[phase];
         rsp_stall_pct = stall_pcts[phase];
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            quiesce();
            case ($urandom_range(0, 9))
               0, 1:    mode_w = rept_pkg::MODE_PLAIN;
               2, 3, 4: mode_w = rept_pkg::MODE_CLAMP;
               9:       mode_w = MODE_UNUSED;
               default: mode_w = rept_pkg::MODE_WRAP;
            endcase
            lo_w = pick_bound();
            hi_w = ($urandom_range(0, 2) != 0) ? lo_w + 32'($urandom_range(0, 300)) - 32'd60
                                               : pick_bound();
            case ($urandom_range(0, 9))
               0: step_w = 16'h8000;
               1: step_w = 16'h7FFF;
               2: step_w = 16'd1;
               3: step_w = 16'hFFFF;
               4: step_w = 16'd0;
               9: step_w = 16'($urandom());
               default: step_w = 16'($urandom_range(0, 40)) - 16'd20;
            endcase
            // Upper data bits beyond a register's width are don't-care.
            rnd = $urandom();
            write_reg(rept_pkg::CSR_RANGE_MODE,
                      {($urandom_range(0, 1) != 0) ? rnd[31:2] : 30'd0, mode_w});
            write_reg(rept_pkg::CSR_BOUND_LOW, lo_w);
            write_reg(rept_pkg::CSR_BOUND_HIGH, hi_w);
            write_reg(rept_pkg::CSR_STEP_SIZE,
                      {($urandom_range(0, 1) != 0) ? rnd[31:16] : {16{step_w[15]}}, step_w});

            seg_words = 0;
            while (seg_words < SEGMENT_WORDS) begin
               n = $urandom_range(0, 99);
               if (!enc_listening && n < 50) begin
                  send_word(rept_pkg::CMD_TOGGLE, 1'($urandom()), 1'($urandom()), $urandom(),
                            1'b0, '0);
                  seg_words++;
               end else if (n < 55) begin
                  // A turn of the knob: clean low-high pairs in one direction.
                  dir = 1'($urandom());
                  repeat ($urandom_range(1, 8)) begin
                     if (enc_listening)
                        seg_words += 2;
                     send_word(rept_pkg::CMD_SAMPLE, 1'b0, 1'($urandom()), $urandom(), 1'b0, '0);
                     send_word(rept_pkg::CMD_SAMPLE, 1'b1, dir, $urandom(), 1'b0, '0);
                  end
               end else if (n < 78 || n >= 98) begin
                  case ($urandom_range(0, 9))
                     0:       rnd = rept_pkg::S32_MIN;
                     1:       rnd = rept_pkg::S32_MAX;
                     2, 3:    rnd = $urandom();
                     4, 5, 6: rnd = cfg_low + 32'($urandom_range(0, 40)) - 32'd20;
                     7, 8:    rnd = cfg_high + 32'($urandom_range(0, 40)) - 32'd20;
                     default: rnd = 32'($urandom_range(0, 2000)) - 32'd1000;
                  endcase
                  send_word(rept_pkg::CMD_READ, 1'($urandom()), 1'($urandom()), rnd, 1'b0, '0);
                  seg_words++;
               end else if (n < 88) begin
                  if (enc_listening)
                     seg_words++;
                  send_word(rept_pkg::CMD_SAMPLE, 1'($urandom()), 1'($urandom()), $urandom(),
                            1'b0, '0);
               end else if (n < 93) begin
                  send_word(rept_pkg::CMD_TOGGLE, 1'($urandom()), 1'($urandom()), $urandom(),
                            1'b0, '0);
                  seg_words++;
               end else if (n < 96) begin
                  send_word(CMD_UNUSED, 1'($urandom()), 1'($urandom()), $urandom(), 1'b0, '0);
               end else begin
                  wait_drained();
               end
            end
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES + 20) @(posedge clock);
      if (expected_positions.size() != 0)
         report_mismatch($sformatf("%0d positions never arrived", expected_positions.size()));
      $display("Covered %0d request words, %0d positions and %0d register writes,",
               words_sent, positions_checked, reg_writes);
      $display("over plain, clamp and wrap settings and three sender/receiver idle mixes.");
      if (mismatches == 0)
         $display("PASS rotary_encoder_position_tracker");
      else
         $display("FAIL rotary_encoder_position_tracker");
      $finish;
   end

endmodule
